// File: rtl/spim_pkg.sv
// Shared types and constants for the SPI master bit engine.
`timescale 1ns / 1ps
`default_nettype none

package spim_pkg;

  // Default width of the shift words.
  localparam int DEFAULT_WORD_WIDTH = 32;

  // Configuration register width and reset values.
  localparam int CFG_W = 6;
  localparam logic [CFG_W-1:0] XFER_BITS_RESET = 6'd8;
  localparam logic [CFG_W-1:0] READ_BITS_RESET = 6'd8;

  // Configuration channel widths and register indexes.
  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_XFER_BITS = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_READ_BITS = 8'd1;

  // Bit position: signed, one bit wider than the config value; all ones means exhausted.
  localparam int POS_W = CFG_W + 1;

  // Width of the reported read word.
  localparam int READ_WORD_W = 32;

  // Input item kinds.
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // One result item.
  typedef struct packed {
    logic [READ_WORD_W-1:0] read_word;
    logic                   done_res;
    logic                   busy_res;
    logic                   data_out_level;
    logic                   clock_level;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/spi_master_bit_engine.sv
// Top level of the tick-driven SPI master bit engine.
// A result is registered and appears on the master side in the cycle after its item transfers.
// Throughput: one item per cycle while the master side takes each result; the single output register sets this figure.
// The input stalls only while a result waits in the output register untaken.
// Reset (synchronous, active high) makes the engine idle, pins high, config to 8 and 8.
`timescale 1ns / 1ps
`default_nettype none

module spi_master_bit_engine #(
  parameter int WORD_WIDTH = spim_pkg::DEFAULT_WORD_WIDTH
) (
  input  wire                              clk,
  input  wire                              rst,
  // Configuration write channel.
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [spim_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire [spim_pkg::CFG_W-1:0]        cfg_data,
  // Input items.
  input  wire                              s_tvalid,
  output logic                             s_tready,
  input  wire [39:0]                       s_tdata,  // write_word[31:0], serial_in[32], zero pad
  input  wire                              s_tuser,  // kind[0]
  // Result items.
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic [39:0]                      m_tdata   // clock_level[0], data_out_level[1],
                                                     // busy_res[2], done_res[3],
                                                     // read_word[35:4], zero pad
);
  import spim_pkg::*;

  logic    item_accept;
  logic    cfg_write;
  logic    can_load;
  result_t result_next;
  result_t result;

  assign cfg_ready   = 1'b1;
  assign cfg_write   = cfg_valid && cfg_ready;
  assign s_tready    = can_load;
  assign item_accept = s_tvalid && s_tready;

  // Bit step and transfer state.
  spim_core #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_accept (item_accept),
    .kind        (s_tuser),
    .write_word  (s_tdata[31:0]),
    .serial_in   (s_tdata[32]),
    .result_next (result_next)
  );

  // Result register toward the master side.
  spim_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (item_accept),
    .result_next (result_next),
    .can_load    (can_load),
    .valid       (m_tvalid),
    .taken       (m_tready),
    .result      (result)
  );

  // Pack the result fields.
  assign m_tdata = {4'b0000, result.read_word, result.done_res, result.busy_res,
                    result.data_out_level, result.clock_level};

endmodule

`default_nettype wire

// File: rtl/spim_core.sv
// Configuration registers, transfer state and the per-item bit step.
`timescale 1ns / 1ps
`default_nettype none

module spim_core #(
  parameter int WORD_WIDTH = spim_pkg::DEFAULT_WORD_WIDTH
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_write,
  input  wire [spim_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire [spim_pkg::CFG_W-1:0]          cfg_data,
  input  wire                                item_accept,
  input  wire                                kind,
  input  wire [31:0]                         write_word,
  input  wire                                serial_in,
  output spim_pkg::result_t                  result_next
);
  import spim_pkg::*;

  logic [CFG_W-1:0]      xfer_bits;
  logic [CFG_W-1:0]      read_bits;

  logic                  active;
  logic                  high_phase;
  logic [POS_W-1:0]      bit_position;
  logic [WORD_WIDTH-1:0] out_word;
  logic [WORD_WIDTH-1:0] in_word;
  logic                  clock_pin;
  logic                  data_pin;

  logic                  active_next;
  logic                  high_phase_next;
  logic [POS_W-1:0]      bit_position_next;
  logic [WORD_WIDTH-1:0] out_word_next;
  logic [WORD_WIDTH-1:0] in_word_next;
  logic                  clock_pin_next;
  logic                  data_pin_next;
  logic                  done_next;

  logic [WORD_WIDTH-1:0] out_shifted;
  logic [WORD_WIDTH-1:0] capture_mask;
  logic                  capture_ok;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      xfer_bits <= XFER_BITS_RESET;
      read_bits <= READ_BITS_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_XFER_BITS) begin
        xfer_bits <= cfg_data;
      end else if (cfg_index == REG_READ_BITS) begin
        read_bits <= cfg_data;
      end
    end
  end

  // Positions at or above the word width shift everything out, which gives
  // a zero output bit and an empty capture mask.
  assign out_shifted  = out_word >> bit_position[CFG_W-1:0];
  assign capture_mask = {{(WORD_WIDTH-1){1'b0}}, 1'b1} << bit_position[CFG_W-1:0];
  assign capture_ok   = !bit_position[POS_W-1] && (bit_position[CFG_W-1:0] < read_bits)
                        && serial_in;

  // One step of the engine for the item at the input.
  always_comb begin
    active_next       = active;
    high_phase_next   = high_phase;
    bit_position_next = bit_position;
    out_word_next     = out_word;
    in_word_next      = in_word;
    clock_pin_next    = clock_pin;
    data_pin_next     = data_pin;
    done_next         = 1'b0;
    if (kind == KIND_START) begin
      bit_position_next = {1'b0, xfer_bits} - {{(POS_W-1){1'b0}}, 1'b1};
      in_word_next      = '0;
      out_word_next     = WORD_WIDTH'(write_word);
      high_phase_next   = 1'b0;
      active_next       = 1'b1;
    end else if (active) begin
      if (!high_phase) begin
        if (bit_position[POS_W-1]) begin
          // Index exhausted: finish the transfer.
          active_next   = 1'b0;
          data_pin_next = 1'b1;
          done_next     = 1'b1;
        end else begin
          data_pin_next   = out_shifted[0];
          clock_pin_next  = 1'b0;
          high_phase_next = 1'b1;
        end
      end else begin
        if (capture_ok) begin
          in_word_next = in_word | capture_mask;
        end
        bit_position_next = bit_position - {{(POS_W-1){1'b0}}, 1'b1};
        clock_pin_next    = 1'b1;
        high_phase_next   = 1'b0;
      end
    end
  end

  // Transfer state advances once per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      high_phase   <= 1'b0;
      bit_position <= '1;
      out_word     <= '0;
      in_word      <= '0;
      clock_pin    <= 1'b1;
      data_pin     <= 1'b1;
    end else if (item_accept) begin
      active       <= active_next;
      high_phase   <= high_phase_next;
      bit_position <= bit_position_next;
      out_word     <= out_word_next;
      in_word      <= in_word_next;
      clock_pin    <= clock_pin_next;
      data_pin     <= data_pin_next;
    end
  end

  // Result reflects the state after the update.
  always_comb begin
    result_next.clock_level    = clock_pin_next;
    result_next.data_out_level = data_pin_next;
    result_next.busy_res       = active_next;
    result_next.done_res       = done_next;
    result_next.read_word      = READ_WORD_W'(in_word_next);
  end

endmodule

`default_nettype wire

// File: rtl/spim_out_reg.sv
// Output register that holds one result until the downstream side takes it.
`timescale 1ns / 1ps
`default_nettype none

module spim_out_reg (
  input  wire                clk,
  input  wire                rst,
  input  wire                load,
  input  spim_pkg::result_t  result_next,
  output logic               can_load,
  output logic               valid,
  input  wire                taken,
  output spim_pkg::result_t  result
);
  import spim_pkg::*;

  // A new result may enter when the register is empty or drains this cycle.
  assign can_load = !valid || taken;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (taken) begin
      valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire
